### sv/tagged_number_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tagged number encoder
// Clocked, reset-qualified property checks; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TAGGED_NUMBER_ENCODER_ASSERT_SVH
`define TAGGED_NUMBER_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TNE_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tne assertion failed");
`define TNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tne assertion failed");
`else
`define TNE_ASSERT_ALWAYS(lbl, expr)
`define TNE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/tne_pkg.sv
// ----------------------------------------------------------------------------
// tne_pkg
// Shared types and constants of the tagged number encoder.
// ----------------------------------------------------------------------------
package tne_pkg;

    // One encoded number: bytes in send order from bit 0 up, and byte count
    typedef struct packed {
        logic [71:0] data;
        logic [3:0]  count;
    } tne_enc_t;

    localparam logic [7:0] PFX_F32 = 8'hca;
    localparam logic [7:0] PFX_F64 = 8'hcb;
    localparam logic [7:0] PFX_U8  = 8'hcc;
    localparam logic [7:0] PFX_U16 = 8'hcd;
    localparam logic [7:0] PFX_U32 = 8'hce;
    localparam logic [7:0] PFX_I8  = 8'hd0;
    localparam logic [7:0] PFX_I16 = 8'hd1;
    localparam logic [7:0] PFX_I32 = 8'hd2;

    // +(2^53-1) as a double, magnitude part
    localparam logic [62:0] SAFE_MAX_MAG = 63'h433f_ffff_ffff_ffff;
    // Significand of the double nearest 1e-4; its weight is 2^-66
    localparam logic [52:0] TOL_MANT = 53'h1a_36e2_eb1c_432d;
    localparam logic [30:0] F32_INF_MAG = 31'h7f80_0000;

endpackage

### sv/tne_core.sv
// ----------------------------------------------------------------------------
// tne_core
// Three-stage pipeline: integer decode, float32 rounding, error test and pack.
// ----------------------------------------------------------------------------
module tne_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [63:0]       value_bits,
    output logic              enc_valid,
    input  logic              enc_take,
    output tne_pkg::tne_enc_t enc
);
    import tne_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || enc_take;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    // ---------------- stage 1: special values, integer form
    logic [63:0] sb;
    logic [10:0] ex0;
    logic [51:0] fr0;
    logic [52:0] mant0, mag53, lowmask;
    logic [5:0]  ish;
    logic        int_ok_next;
    logic [31:0] int_val_next, m32;

    always_comb
    begin
        if (value_bits[62:52] == 11'h7ff)
            sb = (value_bits[51:0] != 52'd0) ? 64'd0 : {value_bits[63], SAFE_MAX_MAG};
        else
            sb = value_bits;
        ex0     = sb[62:52];
        fr0     = sb[51:0];
        mant0   = {1'b1, fr0};
        ish     = 6'(11'd1075 - ex0);
        mag53   = mant0 >> ish;
        lowmask = ~({53{1'b1}} << ish);
        m32     = mag53[31:0];
        int_ok_next  = 1'b0;
        int_val_next = 32'd0;
        if (ex0 == 11'd0)
        begin
            int_ok_next = (fr0 == 52'd0);
        end
        else if (ex0 >= 11'd1023 && ex0 <= 11'd1054)
        begin
            int_ok_next  = ((mant0 & lowmask) == 53'd0) &&
                           (ex0 <= 11'd1053 || (sb[63] && fr0 == 52'd0));
            int_val_next = sb[63] ? (32'd0 - m32) : m32;
        end
    end

    logic [63:0] s1_bits_reg;
    logic        s1_int_ok_reg;
    logic [31:0] s1_int_val_reg;

    // ---------------- stage 2: round to float32
    logic [10:0] ex1;
    logic [52:0] mant1;
    logic [28:0] lo;
    logic        rnd;
    logic [30:0] fmag_next;
    logic [29:0] k_next;
    logic [11:0] tsh;
    logic [10:0] rsh;
    logic [106:0] shd;
    logic        alw_next, nev_next;

    always_comb
    begin
        ex1   = s1_bits_reg[62:52];
        mant1 = {1'b1, s1_bits_reg[51:0]};
        lo    = s1_bits_reg[28:0];
        tsh   = 12'({1'b0, ex1} - 12'd1009);
        rsh   = 11'd926 - ex1;
        shd   = {mant1, 54'd0} >> rsh[5:0];
        rnd   = 1'b0;
        fmag_next = 31'd0;
        k_next    = 30'd0;
        alw_next  = 1'b0;
        nev_next  = 1'b0;
        if (ex1 == 11'd0)
        begin
            alw_next = 1'b1;
        end
        else if (ex1 <= 11'd896)
        begin
            // float32 subnormal or zero; error is far below the tolerance
            alw_next = 1'b1;
            if (rsh < 11'd55)
            begin
                rnd = shd[53] && ((|shd[52:0]) || shd[54]);
                fmag_next = 31'(shd[77:54]) + 31'(rnd);
            end
        end
        else if (ex1 > 11'd1150)
        begin
            nev_next = 1'b1;
        end
        else
        begin
            rnd = lo[28] && ((lo[27:0] != 28'd0) || s1_bits_reg[29]);
            fmag_next = {8'(ex1 - 11'd896), s1_bits_reg[51:29]} + 31'(rnd);
            k_next = rnd ? (30'h2000_0000 - {1'b0, lo}) : {1'b0, lo};
            alw_next = tsh[11] || (k_next == 30'd0);
            nev_next = (fmag_next == F32_INF_MAG) ||
                       (!alw_next && tsh >= 12'd54);
        end
    end

    logic [63:0] s2_bits_reg;
    logic        s2_int_ok_reg;
    logic [31:0] s2_int_val_reg;
    logic [30:0] s2_fmag_reg;
    logic [29:0] s2_k_reg;
    logic [5:0]  s2_tsh_reg;
    logic        s2_alw_reg, s2_nev_reg;

    // ---------------- stage 3: tolerance test and byte packing
    logic [82:0] err_scaled;
    logic        f32_ok;
    logic signed [31:0] t;
    tne_enc_t    enc_next;

    always_comb
    begin
        err_scaled = {53'd0, s2_k_reg} << s2_tsh_reg;
        f32_ok = !s2_nev_reg && (s2_alw_reg || err_scaled < 83'(TOL_MANT));
        t = s2_int_val_reg;
        enc_next.data  = {s2_bits_reg, PFX_F64};
        enc_next.count = 4'd9;
        if (s2_int_ok_reg)
        begin
            if (t >= 0)
            begin
                if (t < 32'sd128)
                begin
                    enc_next.data = {64'd0, t[7:0]};         enc_next.count = 4'd1;
                end
                else if (t < 32'sd256)
                begin
                    enc_next.data = {56'd0, t[7:0], PFX_U8}; enc_next.count = 4'd2;
                end
                else if (t < 32'sd65536)
                begin
                    enc_next.data = {48'd0, t[15:0], PFX_U16}; enc_next.count = 4'd3;
                end
                else
                begin
                    enc_next.data = {32'd0, t, PFX_U32};     enc_next.count = 4'd5;
                end
            end
            else
            begin
                if (t >= -32'sd32)
                begin
                    enc_next.data = {64'd0, t[7:0]};         enc_next.count = 4'd1;
                end
                else if (t >= -32'sd128)
                begin
                    enc_next.data = {56'd0, t[7:0], PFX_I8}; enc_next.count = 4'd2;
                end
                else if (t >= -32'sd32768)
                begin
                    enc_next.data = {48'd0, t[15:0], PFX_I16}; enc_next.count = 4'd3;
                end
                else
                begin
                    enc_next.data = {32'd0, t, PFX_I32};     enc_next.count = 4'd5;
                end
            end
        end
        else if (f32_ok)
        begin
            enc_next.data  = {32'd0, s2_bits_reg[63], s2_fmag_reg, PFX_F32};
            enc_next.count = 4'd5;
        end
    end

    tne_enc_t enc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_bits_reg    <= sb;
            s1_int_ok_reg  <= int_ok_next;
            s1_int_val_reg <= int_val_next;
        end
        if (rdy2)
        begin
            s2_bits_reg    <= s1_bits_reg;
            s2_int_ok_reg  <= s1_int_ok_reg;
            s2_int_val_reg <= s1_int_val_reg;
            s2_fmag_reg    <= fmag_next;
            s2_k_reg       <= k_next;
            s2_tsh_reg     <= tsh[5:0];
            s2_alw_reg     <= alw_next;
            s2_nev_reg     <= nev_next;
        end
        if (rdy3)
            enc_reg <= enc_next;
    end

    assign enc_valid = v3_reg;
    assign enc       = enc_reg;

endmodule

### sv/tne_serialiser.sv
// ----------------------------------------------------------------------------
// tne_serialiser
// Sends a packed encoding one byte per transfer; loads the next on the last.
// ----------------------------------------------------------------------------
`include "tagged_number_encoder_assert.svh"
module tne_serialiser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    output logic              enc_take,
    input  tne_pkg::tne_enc_t enc,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              last_byte
);
    import tne_pkg::*;

    logic        ov_reg;
    logic [3:0]  cnt_reg;
    logic [71:0] buf_reg;
    logic        sent, load;

    assign sent     = ov_reg && !out_stall;
    assign load     = enc_valid && (!ov_reg || (sent && cnt_reg == 4'd1));
    assign enc_take = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            cnt_reg <= 4'd0;
        end
        else if (load)
        begin
            ov_reg  <= 1'b1;
            cnt_reg <= enc.count;
        end
        else if (sent)
        begin
            ov_reg  <= (cnt_reg != 4'd1);
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= enc.data;
        else if (sent)
            buf_reg <= {8'd0, buf_reg[71:8]};
    end

    assign out_valid = ov_reg;
    assign out_byte  = buf_reg[7:0];
    assign last_byte = (cnt_reg == 4'd1);

    `TNE_ASSERT_ALWAYS(a_cnt_range, !ov_reg || (cnt_reg != 4'd0 && cnt_reg <= 4'd9))
    `TNE_ASSERT_NEXT(a_load_data, load, buf_reg == $past(enc.data))
    `TNE_ASSERT_NEXT(a_keep_going, sent && cnt_reg != 4'd1, ov_reg && cnt_reg == $past(cnt_reg) - 4'd1)

endmodule

### sv/tagged_number_encoder.sv
// ----------------------------------------------------------------------------
// tagged_number_encoder
// Encodes IEEE-754 doubles into variable-length tagged byte streams.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with value_bits, one double per transfer.
// Output channel: out_valid / out_stall with out_byte and last_byte, one byte
// per transfer, prefix first; last_byte flags the final byte of a number.
// Forms: int fixints and 0xcc..0xd2 integers, 0xca float32, 0xcb float64.
// NaN goes out as 0x00; infinities as +/-(2^53-1) in the double form.
// A number passes the stage 1, 2 and 3 registers and then the output
// register before its first byte is offered.
// Throughput: one output byte per cycle while out_stall is low; a number is
// 1 to 9 bytes long, and the byte count of the encoding sets the rate.
// Input is taken every cycle while the pipeline has room.
// Reset clears all valid bits; no clearing pass is needed.
// While out_stall is high the output byte holds, and the pipeline fills and
// then raises in_stall; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module tagged_number_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import tne_pkg::*;

    tne_enc_t enc;
    logic     enc_valid;
    logic     enc_take;

    // Classification and packing pipeline
    tne_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .enc_valid  (enc_valid),
        .enc_take   (enc_take),
        .enc        (enc)
    );

    // Byte-wide output register
    tne_serialiser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_take  (enc_take),
        .enc       (enc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule
